/* src/vt4_pkg.sv */
// vt4_pkg: shared constants for the 4x4 vertex transform.
// Used by vt4_cfg, vt4_lane and vertex_transform_4x4_top; depends on nothing.
package vt4_pkg;

  localparam int FIELD_W        = 32;  // width of every vertex component port
  localparam int CFG_INDEX_W    = 8;   // register index carried by the write channel
  localparam int CFG_DATA_W     = 64;  // one register holds two coefficients
  localparam int HALF_W         = 32;  // one coefficient slot inside a register
  localparam int NUM_REGS       = 8;
  localparam int REG_IDX_W      = 3;
  localparam int NUM_COMP       = 4;   // x, y, z, w
  localparam int LANE_LAT       = 3;   // multiply, pair add, final add and clip
  localparam int DATA_WIDTH_DEF = 32;
  localparam int FRAC_BITS_DEF  = 16;

  // Register map: row k, columns 0/1 or 2/3
  localparam logic [REG_IDX_W-1:0] REG_ROW_X_COLS01 = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_ROW_X_COLS23 = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_ROW_Y_COLS01 = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_ROW_Y_COLS23 = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_ROW_Z_COLS01 = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_ROW_Z_COLS23 = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_ROW_W_COLS01 = 3'd6;
  localparam logic [REG_IDX_W-1:0] REG_ROW_W_COLS23 = 3'd7;

endpackage

/* src/vt4_cfg.sv */
// vt4_cfg: matrix coefficient registers, reset to identity.
// Depends on vt4_pkg.
module vt4_cfg #(
  parameter int DATA_WIDTH = vt4_pkg::DATA_WIDTH_DEF,
  parameter int FRAC_BITS  = vt4_pkg::FRAC_BITS_DEF
) (
  input  logic                                                  clk,
  input  logic                                                  rst,
  input  logic                                                  wr_en,
  input  logic [vt4_pkg::CFG_INDEX_W-1:0]                       wr_index,
  input  logic [vt4_pkg::CFG_DATA_W-1:0]                        wr_data,
  output logic [vt4_pkg::NUM_COMP-1:0][vt4_pkg::NUM_COMP-1:0][DATA_WIDTH-1:0] coef
);
  import vt4_pkg::*;

  localparam logic [CFG_DATA_W-1:0] ONE_LO = CFG_DATA_W'(1) << FRAC_BITS;
  localparam logic [CFG_DATA_W-1:0] ONE_HI = ONE_LO << HALF_W;

  logic [CFG_DATA_W-1:0] regs [NUM_REGS];
  logic                  idx_ok;

  assign idx_ok = wr_index < CFG_INDEX_W'(NUM_REGS);

  always_ff @(posedge clk) begin
    if (rst) begin
      regs[REG_ROW_X_COLS01] <= ONE_LO;
      regs[REG_ROW_X_COLS23] <= '0;
      regs[REG_ROW_Y_COLS01] <= ONE_HI;
      regs[REG_ROW_Y_COLS23] <= '0;
      regs[REG_ROW_Z_COLS01] <= '0;
      regs[REG_ROW_Z_COLS23] <= ONE_LO;
      regs[REG_ROW_W_COLS01] <= '0;
      regs[REG_ROW_W_COLS23] <= ONE_HI;
    end else if (wr_en && idx_ok) begin
      regs[wr_index[REG_IDX_W-1:0]] <= wr_data;
    end
  end

  // coef[k][j]: row k, column j; low DATA_WIDTH bits of its half
  for (genvar k = 0; k < NUM_COMP; k++) begin : g_row
    for (genvar j = 0; j < NUM_COMP; j++) begin : g_col
      assign coef[k][j] = regs[k*2 + j/2][(j%2)*HALF_W +: DATA_WIDTH];
    end
  end

endmodule

/* src/vt4_lane.sv */
// vt4_lane: one output component; four products, exact sum, round, clip.
// Depends on vt4_pkg.
module vt4_lane #(
  parameter int DATA_WIDTH = vt4_pkg::DATA_WIDTH_DEF,
  parameter int FRAC_BITS  = vt4_pkg::FRAC_BITS_DEF
) (
  input  logic                                       clk,
  input  logic                                       en,
  input  logic [vt4_pkg::NUM_COMP-1:0][DATA_WIDTH-1:0] vin,
  input  logic [vt4_pkg::NUM_COMP-1:0][DATA_WIDTH-1:0] col,
  output logic signed [DATA_WIDTH-1:0]               result,
  output logic                                       sat
);
  import vt4_pkg::*;

  localparam int PROD_W = 2 * DATA_WIDTH;
  localparam int PAIR_W = PROD_W + 1;
  localparam int SUM_W  = PROD_W + 2;
  localparam logic signed [SUM_W-1:0] HALF = SUM_W'(1) <<< (FRAC_BITS - 1);
  localparam logic signed [SUM_W-1:0] MAXV = (SUM_W'(1) <<< (DATA_WIDTH - 1)) - SUM_W'(1);
  localparam logic signed [SUM_W-1:0] MINV = -MAXV - SUM_W'(1);

  logic signed [PROD_W-1:0] prod [NUM_COMP];
  logic signed [PAIR_W-1:0] pair_lo;
  logic signed [PAIR_W-1:0] pair_hi;
  logic signed [SUM_W-1:0]  total;
  logic signed [SUM_W-1:0]  rounded;
  logic                     over;
  logic                     under;

  // Stage 1: one multiplier per input component
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < NUM_COMP; k++) begin
        prod[k] <= PROD_W'($signed(vin[k])) * PROD_W'($signed(col[k]));
      end
    end
  end

  // Stage 2: pairwise sums
  always_ff @(posedge clk) begin
    if (en) begin
      pair_lo <= PAIR_W'(prod[0]) + PAIR_W'(prod[1]);
      pair_hi <= PAIR_W'(prod[2]) + PAIR_W'(prod[3]);
    end
  end

  // Stage 3: final add with half, arithmetic shift, clip
  assign total   = SUM_W'(pair_lo) + SUM_W'(pair_hi) + HALF;
  assign rounded = total >>> FRAC_BITS;
  assign over    = rounded > MAXV;
  assign under   = rounded < MINV;

  always_ff @(posedge clk) begin
    if (en) begin
      if (over) begin
        result <= MAXV[DATA_WIDTH-1:0];
      end else if (under) begin
        result <= MINV[DATA_WIDTH-1:0];
      end else begin
        result <= rounded[DATA_WIDTH-1:0];
      end
      sat <= over | under;
    end
  end

endmodule

/* src/vertex_transform_4x4_top.sv */
// vertex_transform_4x4_top: homogeneous row vertex times 4x4 matrix, Q fixed point.
// Depends on vt4_pkg, vt4_cfg and vt4_lane.
//
//   Channel   Direction  Handshake              Payload
//   -------   ---------  ---------------------  ---------------------------------
//   in        sink       in_valid / in_stall    in_x, in_y, in_z, in_w
//   out       source     out_valid / out_stall  out_x, out_y, out_z, out_w, saturated
//   cfg       sink       cfg_valid / cfg_ready  cfg_index, cfg_data
//
// One vertex is taken per cycle while the pipeline advances; after its input transfer,
// each result passes the three lane stages and then the merging output register.
// Four lanes, one per output component, each with four DATA_WIDTH multipliers,
// set that rate: every multiplier starts a new product every cycle unless held.
// All stages advance together; when the output register holds a result and
// out_stall is high, the whole pipeline holds and in_stall rises.
// Reset (rst, synchronous) empties the pipeline and loads the identity matrix.
// Configuration writes are always taken (cfg_ready is tied high); indexes past
// the last register are dropped.
module vertex_transform_4x4_top #(
  parameter int DATA_WIDTH = vt4_pkg::DATA_WIDTH_DEF,
  parameter int FRAC_BITS  = vt4_pkg::FRAC_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  // vertex input
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic signed [vt4_pkg::FIELD_W-1:0] in_x,
  input  logic signed [vt4_pkg::FIELD_W-1:0] in_y,
  input  logic signed [vt4_pkg::FIELD_W-1:0] in_z,
  input  logic signed [vt4_pkg::FIELD_W-1:0] in_w,
  // result output
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic signed [vt4_pkg::FIELD_W-1:0] out_x,
  output logic signed [vt4_pkg::FIELD_W-1:0] out_y,
  output logic signed [vt4_pkg::FIELD_W-1:0] out_z,
  output logic signed [vt4_pkg::FIELD_W-1:0] out_w,
  output logic                               saturated,
  // configuration writes
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [vt4_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [vt4_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import vt4_pkg::*;

  // Sign-extended clip limits as they appear on the output ports
  localparam logic [FIELD_W-1:0] OUT_MAX =
    FIELD_W'((64'd1 << (DATA_WIDTH - 1)) - 64'd1);
  localparam logic [FIELD_W-1:0] OUT_MIN = ~OUT_MAX;

  logic                                             adv;
  logic [LANE_LAT-1:0]                              stage_valid;
  logic [NUM_COMP-1:0][DATA_WIDTH-1:0]              vin;
  logic [NUM_COMP-1:0][NUM_COMP-1:0][DATA_WIDTH-1:0] coef;
  logic [NUM_COMP-1:0][DATA_WIDTH-1:0]              lane_res;
  logic [NUM_COMP-1:0]                              lane_sat;
  logic                                             any_limit;

  // Advance whenever the output register is empty or being drained
  assign adv       = !out_valid || !out_stall;
  assign in_stall  = !adv;
  assign cfg_ready = 1'b1;

  // Only the low DATA_WIDTH bits of each component take part
  assign vin[0] = in_x[DATA_WIDTH-1:0];
  assign vin[1] = in_y[DATA_WIDTH-1:0];
  assign vin[2] = in_z[DATA_WIDTH-1:0];
  assign vin[3] = in_w[DATA_WIDTH-1:0];

  vt4_cfg #(
    .DATA_WIDTH (DATA_WIDTH),
    .FRAC_BITS  (FRAC_BITS)
  ) u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .coef     (coef)
  );

  // One lane per output column j; it sees column j of the matrix
  for (genvar j = 0; j < NUM_COMP; j++) begin : g_lane
    logic [NUM_COMP-1:0][DATA_WIDTH-1:0] col;
    for (genvar k = 0; k < NUM_COMP; k++) begin : g_tap
      assign col[k] = coef[k][j];
    end
    vt4_lane #(
      .DATA_WIDTH (DATA_WIDTH),
      .FRAC_BITS  (FRAC_BITS)
    ) u_lane (
      .clk    (clk),
      .en     (adv),
      .vin    (vin),
      .col    (col),
      .result (lane_res[j]),
      .sat    (lane_sat[j])
    );
  end

  // Track which lane stages hold a live vertex
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= '0;
      out_valid   <= 1'b0;
    end else if (adv) begin
      stage_valid <= {stage_valid[LANE_LAT-2:0], in_valid};
      out_valid   <= stage_valid[LANE_LAT-1];
    end
  end

  // Merge: gather the four components, OR the clip flags
  always_ff @(posedge clk) begin
    if (adv) begin
      out_x     <= FIELD_W'($signed(lane_res[0]));
      out_y     <= FIELD_W'($signed(lane_res[1]));
      out_z     <= FIELD_W'($signed(lane_res[2]));
      out_w     <= FIELD_W'($signed(lane_res[3]));
      saturated <= |lane_sat;
    end
  end

  assign any_limit = (out_x == OUT_MAX) || (out_x == OUT_MIN) ||
                     (out_y == OUT_MAX) || (out_y == OUT_MIN) ||
                     (out_z == OUT_MAX) || (out_z == OUT_MIN) ||
                     (out_w == OUT_MAX) || (out_w == OUT_MIN);

  // An empty output register never holds off the input
  a_empty_accepts: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> !in_stall)
    else $error("input stalled with empty output register");

  // A vertex in the last lane stage reaches the output on the next advance
  a_last_stage_out: assert property (@(posedge clk) disable iff (rst)
    (adv && stage_valid[LANE_LAT-1]) |=> out_valid)
    else $error("vertex lost between lanes and output register");

  // A clip flag always comes with at least one component at a limit
  a_sat_at_limit: assert property (@(posedge clk) disable iff (rst)
    (out_valid && saturated) |-> any_limit)
    else $error("saturated set with no component at a limit");

  // Reset leaves no result pending
  a_reset_empty: assert property (@(posedge clk)
    rst |=> (!out_valid && (stage_valid == '0)))
    else $error("pipeline not empty after reset");

endmodule
